// File: sv/ilb_pkg.sv
// Shared types and codes for the indexed list buffer.
`default_nettype none

package ilb_pkg;

   // Operation carried by a request transaction.
   typedef enum logic [2:0] {
      KIND_APPEND = 3'd0,
      KIND_INSERT = 3'd1,
      KIND_REMOVE = 3'd2,
      KIND_GET    = 3'd3,
      KIND_FIND   = 3'd4,
      KIND_CLEAR  = 3'd5
   } kind_type;

   // Status returned with every response transaction.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_RANGE     = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   // Command broadcast to every cell of the chain.
   typedef enum logic [2:0] {
      OP_HOLD       = 3'd0,
      OP_SHIFT_UP   = 3'd1,
      OP_SHIFT_DOWN = 3'd2,
      OP_LOAD_GET   = 3'd3,
      OP_LOAD_FIND  = 3'd4,
      OP_SCAN       = 3'd5
   } cell_op_type;

   // Control sequencer states.
   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

   // Command bundle that the sequencer sends to the cells.
   typedef struct packed {
      cell_op_type op;
      logic        use_count;
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: sv/ilb_cell.sv
// One list entry: word storage, shift mux and a stage of the search chain.
`default_nettype none

module ilb_cell import ilb_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32,
   parameter int INDEX     = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cell_ctl_type                ctl,
   input  wire logic [$clog2(CAPACITY+1)-1:0] pos,
   input  wire logic [$clog2(CAPACITY+1)-1:0] count,
   input  wire logic [WORD_BITS-1:0]        in_word,
   input  wire logic [WORD_BITS-1:0]        left_word,
   input  wire logic [WORD_BITS-1:0]        right_word,
   input  wire logic                        right_hit,
   input  wire logic [WORD_BITS-1:0]        right_acc_word,
   input  wire logic [$clog2(CAPACITY)-1:0] right_acc_idx,
   output logic      [WORD_BITS-1:0]        word,
   output logic                             acc_hit,
   output logic      [WORD_BITS-1:0]        acc_word,
   output logic      [$clog2(CAPACITY)-1:0] acc_idx
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] MY_POS = CW'(INDEX);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [WORD_BITS-1:0] word_ff, word_in;
   logic                 hit_ff, hit_in;
   logic [WORD_BITS-1:0] acc_word_ff, acc_word_in;
   logic [IW-1:0]        acc_idx_ff, acc_idx_in;
   logic                 live;

   // An entry only takes part in a search while it lies below the count.
   assign live = ctl.use_count ? (MY_POS < count) : 1'b1;

   always_comb begin
      word_in     = word_ff;
      hit_in      = hit_ff;
      acc_word_in = acc_word_ff;
      acc_idx_in  = acc_idx_ff;
      case (ctl.op)
         OP_SHIFT_UP: begin
            if (MY_POS > pos) begin
               word_in = left_word;
            end else if (MY_POS == pos) begin
               word_in = in_word;
            end
         end
         OP_SHIFT_DOWN: begin
            if (MY_POS >= pos) begin
               word_in = right_word;
            end
         end
         OP_LOAD_GET: begin
            hit_in      = (MY_POS == pos) && live;
            acc_word_in = word_ff;
            acc_idx_in  = MY_IDX;
         end
         OP_LOAD_FIND: begin
            hit_in      = live && (word_ff == in_word);
            acc_word_in = word_ff;
            acc_idx_in  = MY_IDX;
         end
         OP_SCAN: begin
            // Keep a hit once held, else take the neighbor's partial result.
            if (!hit_ff) begin
               hit_in      = right_hit;
               acc_word_in = right_acc_word;
               acc_idx_in  = right_acc_idx;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
      word_ff     <= word_in;
      acc_word_ff <= acc_word_in;
      acc_idx_ff  <= acc_idx_in;
   end

   assign word     = word_ff;
   assign acc_hit  = hit_ff;
   assign acc_word = acc_word_ff;
   assign acc_idx  = acc_idx_ff;

endmodule

`default_nettype wire

// File: sv/indexed_list_buffer.sv
// Top level of the indexed list buffer: cell chain, sequencer and response queue.
// Append, insert, remove, clear and unused kinds push their result to the response queue on
// acceptance. Get and find load the search chain and answer once the head cell holds a hit
// or every live entry has passed through it (find on an empty list answers without a
// search); one request is in work at a time.
// Synchronous active-high reset empties the list and the response queue; words are kept.
`default_nettype none

module indexed_list_buffer import ilb_pkg::*; #(
   parameter int CAPACITY  = 64,
   parameter int WORD_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [2:0]                    req_kind,
   input  wire logic [$clog2(CAPACITY+1)-1:0] req_position,
   input  wire logic signed [31:0]            req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [1:0]                    rsp_status,
   output logic signed [31:0]                 rsp_read_value,
   output logic      [$clog2(CAPACITY)-1:0]   rsp_found_position,
   output logic      [$clog2(CAPACITY+1)-1:0] rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // Every entry lives in its own cell. A shift moves each word at or past the
   // position one cell; a search loads a hit flag into every cell and then moves
   // partial results one cell toward the head each cycle, so after k steps the
   // head cell holds the first hit among positions 0 through k.
   logic [WORD_BITS-1:0] cell_word     [CAPACITY];
   logic                 cell_hit      [CAPACITY+1];
   logic [WORD_BITS-1:0] cell_acc_word [CAPACITY+1];
   logic [IW-1:0]        cell_acc_idx  [CAPACITY+1];

   logic [WORD_BITS-1:0] in_word;
   logic [31:0]          head_read;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_left_ff, scan_left_in;
   logic          is_get_ff, is_get_in;
   cell_ctl_type  ctl;
   logic [CW-1:0] cell_pos;

   // Result produced this cycle, headed for the response queue.
   logic          push;
   status_type    push_status;
   logic [31:0]   push_read;
   logic [IW-1:0] push_fpos;
   logic [CW-1:0] push_count;
   logic          req_fire, pop;

   // Two-entry response queue: the output register plus a skid slot, so a
   // request can be taken while an earlier response still waits.
   logic          rsp_valid_ff, skid_valid_ff;
   logic [1:0]    rsp_status_ff, skid_status_ff;
   logic [31:0]   rsp_read_ff, skid_read_ff;
   logic [IW-1:0] rsp_fpos_ff, skid_fpos_ff;
   logic [CW-1:0] rsp_count_ff, skid_count_ff;

   // The request word keeps its low WORD_BITS bits; wider words are zero filled.
   // A word read back is sign-extended from WORD_BITS and cut to 32 bits.
   generate
      if (WORD_BITS <= 32) begin : g_narrow
         assign in_word   = req_value[WORD_BITS-1:0];
         assign head_read = {{(32-WORD_BITS){cell_acc_word[0][WORD_BITS-1]}},
                             cell_acc_word[0]};
      end else begin : g_wide
         assign in_word   = {{(WORD_BITS-32){1'b0}}, req_value};
         assign head_read = cell_acc_word[0][31:0];
      end
   endgenerate

   assign cell_hit[CAPACITY]      = 1'b0;
   assign cell_acc_word[CAPACITY] = '0;
   assign cell_acc_idx[CAPACITY]  = '0;

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         logic [WORD_BITS-1:0] left_w;
         logic [WORD_BITS-1:0] right_w;
         if (i == 0) begin : g_head
            assign left_w = in_word;
         end else begin : g_body
            assign left_w = cell_word[i-1];
         end
         if (i == CAPACITY - 1) begin : g_tail
            assign right_w = '0;
         end else begin : g_inner
            assign right_w = cell_word[i+1];
         end
         ilb_cell #(
            .CAPACITY (CAPACITY),
            .WORD_BITS(WORD_BITS),
            .INDEX    (i)
         ) u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctl           (ctl),
            .pos           (cell_pos),
            .count         (count_ff),
            .in_word       (in_word),
            .left_word     (left_w),
            .right_word    (right_w),
            .right_hit     (cell_hit[i+1]),
            .right_acc_word(cell_acc_word[i+1]),
            .right_acc_idx (cell_acc_idx[i+1]),
            .word          (cell_word[i]),
            .acc_hit       (cell_hit[i]),
            .acc_word      (cell_acc_word[i]),
            .acc_idx       (cell_acc_idx[i])
         );
      end
   endgenerate

   // A new transaction is taken only while no search runs and the skid slot is free.
   assign req_ready = (state_ff == ST_IDLE) && !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign pop       = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      scan_left_ff <= scan_left_in;
      is_get_ff    <= is_get_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_left_in = scan_left_ff;
      is_get_in    = is_get_ff;
      ctl.op       = OP_HOLD;
      ctl.use_count = 1'b0;
      cell_pos     = req_position;
      push         = 1'b0;
      push_status  = STATUS_OK;
      push_read    = '0;
      push_fpos    = '0;
      push_count   = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               push = 1'b1;
               case (kind_type'(req_kind))
                  KIND_APPEND: begin
                     // An append is an insert at the current end.
                     cell_pos = count_ff;
                     if (count_ff == CAP_C) begin
                        push_status = STATUS_FULL;
                     end else begin
                        ctl.op   = OP_SHIFT_UP;
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  KIND_INSERT: begin
                     // The range check wins over the full check.
                     if (req_position > count_ff) begin
                        push_status = STATUS_RANGE;
                     end else if (count_ff == CAP_C) begin
                        push_status = STATUS_FULL;
                     end else begin
                        ctl.op   = OP_SHIFT_UP;
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  KIND_REMOVE: begin
                     if (req_position >= count_ff) begin
                        push_status = STATUS_RANGE;
                     end else begin
                        ctl.op   = OP_SHIFT_DOWN;
                        count_in = CW'(count_ff - 1'b1);
                     end
                  end
                  KIND_GET: begin
                     if (req_position >= count_ff) begin
                        push_status = STATUS_RANGE;
                     end else begin
                        push          = 1'b0;
                        ctl.op        = OP_LOAD_GET;
                        ctl.use_count = 1'b1;
                        state_in      = ST_SCAN;
                        scan_left_in  = CW'(count_ff - 1'b1);
                        is_get_in     = 1'b1;
                     end
                  end
                  KIND_FIND: begin
                     if (count_ff == '0) begin
                        push_status = STATUS_NOT_FOUND;
                     end else begin
                        push          = 1'b0;
                        ctl.op        = OP_LOAD_FIND;
                        ctl.use_count = 1'b1;
                        state_in      = ST_SCAN;
                        scan_left_in  = CW'(count_ff - 1'b1);
                        is_get_in     = 1'b0;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               push_count = count_in;
            end
         end
         ST_SCAN: begin
            // Stop as soon as the head cell holds a hit, or once every live
            // entry has passed through it.
            if (cell_hit[0] || (scan_left_ff == '0)) begin
               push     = 1'b1;
               state_in = ST_IDLE;
               if (cell_hit[0]) begin
                  if (is_get_ff) begin
                     push_read = head_read;
                  end else begin
                     push_fpos = cell_acc_idx[0];
                  end
               end else begin
                  push_status = STATUS_NOT_FOUND;
               end
            end else begin
               ctl.op       = OP_SCAN;
               scan_left_in = CW'(scan_left_ff - 1'b1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response queue. A push never meets a full skid slot, because requests
   // are refused while it is occupied and a search starts with it empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            rsp_status_ff <= skid_status_ff;
            rsp_read_ff   <= skid_read_ff;
            rsp_fpos_ff   <= skid_fpos_ff;
            rsp_count_ff  <= skid_count_ff;
            if (push) begin
               skid_status_ff <= push_status;
               skid_read_ff   <= push_read;
               skid_fpos_ff   <= push_fpos;
               skid_count_ff  <= push_count;
            end else begin
               skid_valid_ff <= 1'b0;
            end
         end else if (push) begin
            rsp_status_ff <= push_status;
            rsp_read_ff   <= push_read;
            rsp_fpos_ff   <= push_fpos;
            rsp_count_ff  <= push_count;
         end else begin
            rsp_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= push_status;
            rsp_read_ff   <= push_read;
            rsp_fpos_ff   <= push_fpos;
            rsp_count_ff  <= push_count;
         end else begin
            skid_valid_ff  <= 1'b1;
            skid_status_ff <= push_status;
            skid_read_ff   <= push_read;
            skid_fpos_ff   <= push_fpos;
            skid_count_ff  <= push_count;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_count          = rsp_count_ff;

   // The list never holds more entries than the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("entry count above capacity");

   // The skid slot is only ever filled behind an occupied output register.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot holds a transaction ahead of the output register");

   // An accepted append on a list with room grows the count by one.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_kind == KIND_APPEND) && (count_ff != CAP_C))
      |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("append did not grow the list");

   // The remaining search steps never reach past the live entries.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_left_ff < count_ff))
      else $error("search runs past the end of the list");

   // A get always finds its entry by the last search step.
   a_get_hits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && is_get_ff && (scan_left_ff == '0)) |-> cell_hit[0])
      else $error("get search ended without a hit");

endmodule

`default_nettype wire
